[design/kmnca_pkg.sv]
package kmnca_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_CENTERS_DEF = 16;
    localparam int MAX_DIMS_DEF    = 16;
    localparam int COORD_BITS_DEF  = 16;

    // Fixed field widths
    localparam int ACT_W     = 2;
    localparam int IDX_W     = 4;
    localparam int PREV_W    = 5;
    localparam int LABEL_W   = 4;
    localparam int DIST_W    = 19;
    localparam int CHG_W     = 24;
    localparam int ERR_W     = 40;
    localparam int SUM_W     = 38;
    localparam int ROOT_W    = SUM_W + 2;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_RESET   = 5'd16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POINT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START = 2'd2;

    // Saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CHG_W-1:0] CHG_MAX = '1;
    localparam logic [ERR_W-1:0] ERR_MAX = '1;

    // Magnitude at or above which a square saturates the sum
    localparam logic [63:0] MAG_LIMIT = 64'(1) << (SUM_W / 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

[design/kmnca_ram.sv]
module kmnca_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/kmeans_nearest_center_assign_core.sv]
// Nearest-center assignment for k-means, Euclidean metric.
// Input channel (in_valid/in_ready) carries one item per coordinate:
//   load action writes one coordinate of one center into the center RAM,
//   start action clears the change and distance totals,
//   point action feeds one signed Q8.8 coordinate of the current point.
// Loads, starts and ignored items leave the block idle and ready for the
// next item. A point coordinate walks the centers in use through one
// subtract/square/accumulate unit, one center per cycle, then a two-stage
// pipeline drain; in_ready stays low until the drain ends, so a new
// coordinate is only taken once the previous one has been scanned.
// The last coordinate in use then runs a 20-step digit-by-digit square
// root and a totals update, after which one item appears on the output
// channel (out_valid/out_ready): label, distance, changed flag and the
// saturating totals. in_ready is high only when idle.
// The result sits in an output register, so the block takes new items
// while the receiver stalls; a further result waits until it drains.
// Config port (cfg_valid/cfg_ready) is always ready; write it only when
// idle. Reset sets both counts to 16, zeroes the totals and marks all
// partial sums empty. Center RAM contents are undefined until loaded.
module kmeans_nearest_center_assign_core
    import kmnca_pkg::*;
#(
    parameter int MAX_CENTERS = MAX_CENTERS_DEF,
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ACT_W-1:0]             action,
    input  logic [IDX_W-1:0]             center_index,
    input  logic [IDX_W-1:0]             coord_index,
    input  logic signed [COORD_BITS-1:0] coord_value,
    input  logic [PREV_W-1:0]            previous_label,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LABEL_W-1:0]           label,
    output logic [DIST_W-1:0]            distance,
    output logic                         changed,
    output logic [CHG_W-1:0]             change_total,
    output logic [ERR_W-1:0]             error_total
);

    localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CNT_W  = $clog2(MAX_CENTERS + 1);
    localparam int DCNT_W = $clog2(MAX_DIMS + 1);
    localparam int DEPTH  = MAX_CENTERS * MAX_DIMS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int HALF_W = SUM_W / 2;

    // ---------------- control registers ----------------
    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      centers_cfg_reg, dims_cfg_reg;
    logic [CNT_W-1:0]      issue_cnt_reg;
    logic                  v1_reg, v2_reg;
    logic [MAX_CENTERS-1:0] psum_vld_reg;
    logic [CHG_W-1:0]      change_count_reg;
    logic [ERR_W-1:0]      distance_sum_reg;
    logic                  out_valid_reg;

    // ---------------- payload registers ----------------
    logic [IDX_W-1:0]      didx_reg;
    logic [COORD_BITS-1:0] val_reg;
    logic [PREV_W-1:0]     prev_reg;
    logic                  first_reg, last_reg;
    logic [CIDX_W-1:0]     j1_reg, j2_reg;
    logic [SUM_W-1:0]      sq_reg, old_reg;
    logic [SUM_W-1:0]      best_sum_reg;
    logic [CIDX_W-1:0]     best_idx_reg;
    logic [SUM_W-1:0]      x_reg;
    logic [ROOT_W-1:0]     res_reg, bit_reg;
    logic [LABEL_W-1:0]    label_reg;
    logic [DIST_W-1:0]     distance_reg;
    logic                  changed_reg;
    logic [CHG_W-1:0]      change_total_reg;
    logic [ERR_W-1:0]      error_total_reg;

    // ---------------- combinational ----------------
    logic [CNT_W-1:0]      k_count;
    logic [DCNT_W-1:0]     d_count;
    logic                  in_fire, cfg_fire;
    logic                  load_ok, point_ok;
    logic                  issue_en, scan_done, root_last, out_free, finish;
    logic [CIDX_W-1:0]     j_issue;
    logic [AW-1:0]         load_addr, scan_addr;
    logic                  center_we;
    logic [COORD_BITS-1:0] center_q;
    logic [SUM_W-1:0]      psum_q;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]     mag;
    logic [63:0]           mag64;
    logic [HALF_W-1:0]     mag_lo;
    logic [SUM_W-1:0]      sq, old;
    logic [SUM_W:0]        sum_ext;
    logic [SUM_W-1:0]      sum_sat;
    logic [ROOT_W-1:0]     trial;
    logic                  take;
    logic                  chg;
    logic [CHG_W-1:0]      cnt_new;
    logic [ERR_W:0]        err_ext;
    logic [ERR_W-1:0]      err_new;

    // Register values clamped to 1..max
    always_comb
    begin
        if (centers_cfg_reg == '0)
            k_count = CNT_W'(1);
        else if (32'(centers_cfg_reg) > MAX_CENTERS)
            k_count = CNT_W'(MAX_CENTERS);
        else
            k_count = CNT_W'(centers_cfg_reg);

        if (dims_cfg_reg == '0)
            d_count = DCNT_W'(1);
        else if (32'(dims_cfg_reg) > MAX_DIMS)
            d_count = DCNT_W'(MAX_DIMS);
        else
            d_count = DCNT_W'(dims_cfg_reg);
    end

    assign in_fire  = in_valid && in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign load_ok  = (32'(center_index) < MAX_CENTERS) && (32'(coord_index) < MAX_DIMS);
    assign point_ok = 32'(coord_index) < 32'(d_count);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && action == ACT_POINT && point_ok)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = last_reg ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                if (root_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        issue_en  = (state_reg == ST_SCAN) && (issue_cnt_reg != k_count);
        scan_done = (state_reg == ST_SCAN) && !issue_en && !v1_reg && !v2_reg;
        root_last = (state_reg == ST_ROOT) && bit_reg[0];
        out_free  = !out_valid_reg || out_ready;
        finish    = (state_reg == ST_DONE) && out_free;
        center_we = in_fire && (action == ACT_LOAD) && load_ok;
    end

    assign j_issue   = issue_cnt_reg[CIDX_W-1:0];
    assign load_addr = AW'(32'(center_index) * MAX_DIMS + 32'(coord_index));
    assign scan_addr = AW'(32'(j_issue) * MAX_DIMS + 32'(didx_reg));

    // Center store: entry = center * MAX_DIMS + coordinate
    kmnca_ram #(
        .WIDTH  (COORD_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_center_ram (
        .clk   (clk),
        .we    (center_we),
        .waddr (load_addr),
        .wdata (coord_value),
        .raddr (scan_addr),
        .rdata (center_q)
    );

    // Per-center partial sums; read at issue, written back from stage 2
    kmnca_ram #(
        .WIDTH  (SUM_W),
        .DEPTH  (MAX_CENTERS),
        .ADDR_W (CIDX_W)
    ) u_psum_ram (
        .clk   (clk),
        .we    (v2_reg),
        .waddr (j2_reg),
        .wdata (sum_sat),
        .raddr (j_issue),
        .rdata (psum_q)
    );

    // Stage 1: difference, magnitude, saturating square
    always_comb
    begin
        diff   = $signed({center_q[COORD_BITS-1], center_q})
               - $signed({val_reg[COORD_BITS-1], val_reg});
        mag    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag64  = 64'(mag);
        mag_lo = mag64[HALF_W-1:0];
        sq     = (mag64 >= MAG_LIMIT) ? SUM_MAX : (SUM_W'(mag_lo) * SUM_W'(mag_lo));
        old    = (first_reg || !psum_vld_reg[j1_reg]) ? '0 : psum_q;
    end

    // Stage 2: saturating accumulate
    assign sum_ext = {1'b0, old_reg} + {1'b0, sq_reg};
    assign sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

    // Square root step: one result bit per cycle, two radicand bits at a time
    assign trial = res_reg + bit_reg;
    assign take  = ROOT_W'(x_reg) >= trial;

    // Totals for the finishing item
    assign chg     = 8'(prev_reg) != 8'(best_idx_reg);
    assign cnt_new = (chg && change_count_reg != CHG_MAX) ? change_count_reg + CHG_W'(1)
                                                          : change_count_reg;
    assign err_ext = {1'b0, distance_sum_reg} + (ERR_W + 1)'(res_reg[DIST_W-1:0]);
    assign err_new = err_ext[ERR_W] ? ERR_MAX : err_ext[ERR_W-1:0];

    // ---------------- control sequential ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            centers_cfg_reg  <= CFG_RESET;
            dims_cfg_reg     <= CFG_RESET;
            issue_cnt_reg    <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            psum_vld_reg     <= '0;
            change_count_reg <= '0;
            distance_sum_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_CENTERS: centers_cfg_reg <= cfg_data;
                    REG_DIMS:    dims_cfg_reg    <= cfg_data;
                    default:     ;
                endcase
            end

            if (in_fire)
                issue_cnt_reg <= '0;
            else if (issue_en)
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);

            v1_reg <= issue_en;
            v2_reg <= v1_reg;

            // coordinate zero empties every sum
            if (in_fire && action == ACT_POINT && point_ok && coord_index == '0)
                psum_vld_reg <= '0;
            else if (v2_reg)
                psum_vld_reg[j2_reg] <= 1'b1;

            if (in_fire && action == ACT_START)
            begin
                change_count_reg <= '0;
                distance_sum_reg <= '0;
            end
            else if (finish)
            begin
                change_count_reg <= cnt_new;
                distance_sum_reg <= err_new;
            end

            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath sequential ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            didx_reg  <= coord_index;
            val_reg   <= coord_value;
            prev_reg  <= previous_label;
            first_reg <= (coord_index == '0);
            last_reg  <= (32'(coord_index) == 32'(d_count) - 1);
        end

        j1_reg  <= j_issue;
        j2_reg  <= j1_reg;
        sq_reg  <= sq;
        old_reg <= old;

        if (v2_reg && last_reg && (j2_reg == '0 || sum_sat < best_sum_reg))
        begin
            best_sum_reg <= sum_sat;
            best_idx_reg <= j2_reg;
        end

        if (scan_done)
        begin
            x_reg   <= best_sum_reg;
            res_reg <= '0;
            bit_reg <= ROOT_W'(1) << SUM_W;
        end
        else if (state_reg == ST_ROOT)
        begin
            if (take)
            begin
                x_reg   <= x_reg - trial[SUM_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if (finish)
        begin
            label_reg        <= LABEL_W'(best_idx_reg);
            distance_reg     <= res_reg[DIST_W-1:0];
            changed_reg      <= chg;
            change_total_reg <= cnt_new;
            error_total_reg  <= err_new;
        end
    end

    assign out_valid    = out_valid_reg;
    assign label        = label_reg;
    assign distance     = distance_reg;
    assign changed      = changed_reg;
    assign change_total = change_total_reg;
    assign error_total  = error_total_reg;

endmodule

[design/kmnca_checker.sv]
module kmnca_checker
    import kmnca_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [LABEL_W-1:0] label,
    input logic [DIST_W-1:0]  distance,
    input logic               changed,
    input logic [CHG_W-1:0]   change_total,
    input logic [ERR_W-1:0]   error_total
);

    // no result while held in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(label) && $stable(distance)
            && $stable(changed) && $stable(change_total) && $stable(error_total))
        else $error("stalled result changed");

    // a change is always counted
    a_change_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed |-> change_total != '0)
        else $error("changed item with zero change total");

    // the running total includes this item's distance
    a_error_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> error_total >= ERR_W'(distance))
        else $error("error total below distance");

endmodule

bind kmeans_nearest_center_assign_core kmnca_checker u_kmnca_checker (.*);
